@@ rtl/assert_macros.svh @@
// Assertion macros shared by the coalescer modules.
// Each macro expects signals named clk and rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/sbrc_pkg.sv @@
// Package for the selected block range coalescer: constants, codes and types.
// No dependencies; every other source file but assert_macros.svh imports it.
`timescale 1ns / 1ps

package sbrc_pkg;

  localparam int MAX_BLOCKS   = 4096;
  localparam int MAX_EXPERTS  = 4096;
  localparam int HEADER_BYTES = 128;

  localparam int EXPERT_W = 12;
  localparam int BLOCK_W  = 12;
  localparam int COUNT_W  = 13;
  localparam int TOTAL_W  = 12;
  localparam int NUM_W    = 13;
  localparam int REC_W    = 37;
  localparam int CAP_W    = 12;
  localparam int OFF_W    = 60;
  localparam int LEN_W    = 49;

  localparam int IDX_W    = EXPERT_W + NUM_W;
  localparam int REC_LO_W = 19;
  localparam int REC_HI_W = REC_W - REC_LO_W;
  localparam int PROD_W   = IDX_W + REC_LO_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 64;

  typedef enum logic [1:0] {
    REG_EXPERT_COUNT  = 2'd0,
    REG_EXPERT_BLOCKS = 2'd1,
    REG_REC_SIZE      = 2'd2,
    REG_MAX_RANGES    = 2'd3
  } reg_index_t;

  typedef enum logic {
    KIND_RANGE   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_CAPACITY = 2'd2
  } status_t;

  typedef struct packed {
    logic [NUM_W-1:0] expert_count;
    logic [NUM_W-1:0] expert_blocks;
    logic [REC_W-1:0] rec_size;
    logic [CAP_W-1:0] max_ranges;
  } cfg_t;

  typedef struct packed {
    kind_t               kind;
    status_t             status;
    logic [EXPERT_W-1:0] expert;
    logic [BLOCK_W-1:0]  first;
    logic [COUNT_W-1:0]  count;
    logic [TOTAL_W-1:0]  total;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INDEX,
    ST_OFF_LO,
    ST_OFF_HI,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_SEND
  } back_state_t;

endpackage

@@ rtl/sbrc_in_if.sv @@
// Channel interface for selection flag items.
// Depends on sbrc_pkg for field widths.
`timescale 1ns / 1ps

interface sbrc_in_if import sbrc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [EXPERT_W-1:0] expert_number;
  logic                selected;
  logic                last_flag;

  modport source (output valid, expert_number, selected, last_flag, input ready);
  modport sink (input valid, expert_number, selected, last_flag, output ready);
endinterface

@@ rtl/sbrc_out_if.sv @@
// Channel interface for range and summary items.
// Depends on sbrc_pkg for field widths.
`timescale 1ns / 1ps

interface sbrc_out_if import sbrc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [1:0]         status;
  logic [OFF_W-1:0]   range_offset;
  logic [LEN_W-1:0]   range_length;
  logic [BLOCK_W-1:0] start_block;
  logic [COUNT_W-1:0] run_blocks;
  logic [TOTAL_W-1:0] range_total;
  logic               last;

  modport source (output valid, kind, status, range_offset, range_length, start_block,
                  run_blocks, range_total, last, input ready);
  modport sink (input valid, kind, status, range_offset, range_length, start_block,
                run_blocks, range_total, last, output ready);
endinterface

@@ rtl/sbrc_front.sv @@
// Front end: accepts flag items, tracks runs and faults, and queues range and summary commands.
// Depends on sbrc_pkg and sbrc_in_if.
`timescale 1ns / 1ps

module sbrc_front import sbrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  sbrc_in_if.sink     flag_ch,
  input  logic        space,
  output logic [1:0]  push_n,
  output cmd_t        cmd0,
  output cmd_t        cmd1
);

  logic [NUM_W-1:0]    block_position, block_position_next;
  logic                inside_run, inside_run_next;
  logic [BLOCK_W-1:0]  run_begin, run_begin_next;
  logic [TOTAL_W-1:0]  ranges_done, ranges_done_next;
  status_t             fault_code, fault_code_next;
  logic [EXPERT_W-1:0] pass_expert, pass_expert_next;

  logic                accept;
  logic                first_flag;
  logic [EXPERT_W-1:0] eff_expert;
  logic                eff_inside;
  logic [BLOCK_W-1:0]  eff_begin;
  logic [TOTAL_W-1:0]  eff_ranges;
  status_t             fault0, fault1;
  logic                sel, lst;
  logic                close_now, emit;
  logic [COUNT_W-1:0]  run_end;
  logic [COUNT_W-1:0]  run_count;
  cmd_t                range_cmd, sum_cmd;

  assign flag_ch.ready = space;
  assign accept = flag_ch.valid && space;
  assign sel = flag_ch.selected;
  assign lst = flag_ch.last_flag;

  always_comb begin
    first_flag = (block_position == '0);
    eff_expert = first_flag ? flag_ch.expert_number : pass_expert;
    eff_inside = first_flag ? 1'b0 : inside_run;
    eff_begin  = first_flag ? '0 : run_begin;
    eff_ranges = first_flag ? '0 : ranges_done;

    if (first_flag) begin
      fault0 = (({1'b0, flag_ch.expert_number} >= cfg.expert_count) ||
                (32'(flag_ch.expert_number) >= MAX_EXPERTS) ||
                (cfg.expert_blocks == '0) ||
                (32'(cfg.expert_blocks) > MAX_BLOCKS)) ? STATUS_INVALID : STATUS_OK;
    end else begin
      fault0 = fault_code;
    end

    fault1 = fault0;
    if (block_position >= cfg.expert_blocks) begin
      fault1 = STATUS_INVALID;
    end
    if (lst && ((NUM_W + 1)'(block_position) + 1'b1 !=
                (NUM_W + 1)'(cfg.expert_blocks))) begin
      fault1 = STATUS_INVALID;
    end

    run_begin_next = (sel && !eff_inside) ? block_position[BLOCK_W-1:0] : eff_begin;
    close_now = (!sel && eff_inside) || (lst && (sel || eff_inside));
    run_end   = sel ? block_position + 1'b1 : block_position;
    run_count = run_end - {1'b0, run_begin_next};

    emit = close_now && (fault1 == STATUS_OK) &&
           ({1'b0, eff_ranges} < {1'b0, cfg.max_ranges});
    fault_code_next = fault1;
    if (close_now && (fault1 == STATUS_OK) && !emit) begin
      fault_code_next = STATUS_CAPACITY;
    end

    ranges_done_next = eff_ranges + TOTAL_W'(emit);
    inside_run_next  = sel && !lst;
    pass_expert_next = eff_expert;

    if (lst) begin
      block_position_next = '0;
    end else if (32'(block_position) < MAX_BLOCKS + 1) begin
      block_position_next = block_position + 1'b1;
    end else begin
      block_position_next = block_position;
    end

    range_cmd.kind   = KIND_RANGE;
    range_cmd.status = STATUS_OK;
    range_cmd.expert = eff_expert;
    range_cmd.first  = run_begin_next;
    range_cmd.count  = run_count;
    range_cmd.total  = '0;

    sum_cmd.kind   = KIND_SUMMARY;
    sum_cmd.status = fault_code_next;
    sum_cmd.expert = '0;
    sum_cmd.first  = '0;
    sum_cmd.count  = '0;
    sum_cmd.total  = ranges_done_next;

    cmd0   = emit ? range_cmd : sum_cmd;
    cmd1   = sum_cmd;
    push_n = accept ? (2'(emit) + 2'(lst)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_position <= '0;
      inside_run     <= 1'b0;
      run_begin      <= '0;
      ranges_done    <= '0;
      fault_code     <= STATUS_OK;
      pass_expert    <= '0;
    end else if (accept) begin
      block_position <= block_position_next;
      inside_run     <= inside_run_next;
      run_begin      <= run_begin_next;
      ranges_done    <= ranges_done_next;
      fault_code     <= fault_code_next;
      pass_expert    <= pass_expert_next;
    end
  end

endmodule

@@ rtl/sbrc_queue.sv @@
// Command queue between front and back; takes up to two commands a cycle, gives one.
// Depends on sbrc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbrc_queue import sbrc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_n,
  input  cmd_t       cmd0,
  input  cmd_t       cmd1,
  output logic       space,
  output logic       q_valid,
  output cmd_t       q_cmd,
  input  logic       q_pop
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp, rp;
  logic [QCNT_W-1:0] count, count_next;
  logic [QPTR_W-1:0] wp_plus;

  assign wp_plus = wp + 1'b1;
  assign space   = (32'(count) <= QUEUE_DEPTH - 2);
  assign q_valid = (count != '0);
  assign q_cmd   = entries[rp];
  assign count_next = count + QCNT_W'(push_n) - QCNT_W'(q_pop);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[wp] <= cmd0;
    end
    if (push_n == 2'd2) begin
      entries[wp_plus] <= cmd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + QPTR_W'(push_n);
      rp    <= rp + QPTR_W'(q_pop);
      count <= count_next;
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, push_n != 2'd0, 32'(count) + 32'(push_n) <= QUEUE_DEPTH, "command queue overflow")
  `ASSERT_IMPLIES(a_pop_nonempty, q_pop, count != '0, "pop from empty command queue")

endmodule

@@ rtl/sbrc_back.sv @@
// Back end: turns queued commands into result items, computing offsets and lengths
// with one shared multiplier over several steps. Depends on sbrc_pkg, sbrc_out_if.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbrc_back import sbrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  sbrc_out_if.source  range_ch
);

  back_state_t state, state_next;

  cmd_t               cur;
  logic [IDX_W-1:0]   idx;
  logic [OFF_W-1:0]   off_acc;
  logic [LEN_W-1:0]   len_acc;

  logic [IDX_W-1:0]    mul_a;
  logic [REC_LO_W-1:0] mul_b;
  logic [PROD_W-1:0]   prod;
  logic [IDX_W-1:0]    idx_calc;

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign idx_calc = (IDX_W'(cur.expert) * IDX_W'(cfg.expert_blocks)) +
                    IDX_W'(cur.first);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = (q_cmd.kind == KIND_SUMMARY) ? ST_SEND : ST_INDEX;
        end
      end
      ST_INDEX:  state_next = ST_OFF_LO;
      ST_OFF_LO: state_next = ST_OFF_HI;
      ST_OFF_HI: state_next = ST_LEN_LO;
      ST_LEN_LO: state_next = ST_LEN_HI;
      ST_LEN_HI: state_next = ST_SEND;
      ST_SEND: begin
        if (range_ch.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    mul_a = '0;
    mul_b = '0;
    range_ch.valid = 1'b0;
    unique case (state)
      ST_IDLE:   q_pop = q_valid;
      ST_OFF_LO: begin
        mul_a = idx;
        mul_b = cfg.rec_size[REC_LO_W-1:0];
      end
      ST_OFF_HI: begin
        mul_a = idx;
        mul_b = REC_LO_W'(cfg.rec_size[REC_W-1:REC_LO_W]);
      end
      ST_LEN_LO: begin
        mul_a = IDX_W'(cur.count);
        mul_b = cfg.rec_size[REC_LO_W-1:0];
      end
      ST_LEN_HI: begin
        mul_a = IDX_W'(cur.count);
        mul_b = REC_LO_W'(cfg.rec_size[REC_W-1:REC_LO_W]);
      end
      ST_SEND:   range_ch.valid = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          cur     <= q_cmd;
          off_acc <= '0;
          len_acc <= '0;
        end
      end
      ST_INDEX:  idx <= idx_calc;
      ST_OFF_LO: off_acc <= OFF_W'(HEADER_BYTES) + OFF_W'(prod);
      ST_OFF_HI: off_acc <= off_acc + OFF_W'({prod, {REC_LO_W{1'b0}}});
      ST_LEN_LO: len_acc <= LEN_W'(prod);
      ST_LEN_HI: len_acc <= len_acc + LEN_W'({prod, {REC_LO_W{1'b0}}});
      default: begin
      end
    endcase
  end

  assign range_ch.kind         = cur.kind;
  assign range_ch.status       = cur.status;
  assign range_ch.range_offset = off_acc;
  assign range_ch.range_length = len_acc;
  assign range_ch.start_block  = cur.first;
  assign range_ch.run_blocks   = cur.count;
  assign range_ch.range_total  = cur.total;
  assign range_ch.last         = (cur.kind == KIND_SUMMARY);

  `ASSERT_IMPLIES(a_range_ok, range_ch.valid && (cur.kind == KIND_RANGE),
                  (cur.status == STATUS_OK) && (cur.total == '0),
                  "range item carries summary fields")

endmodule

@@ rtl/selected_block_range_coalescer_core.sv @@
// Top level of the selected block range coalescer: configuration registers and
// the front, queue and back parts. Depends on sbrc_pkg, the channel interfaces and submodules.
//
//   channel    direction  payload
//   flag_ch    in         expert_number, selected, last_flag
//   range_ch   out        kind, status, range_offset, range_length, start_block,
//                         run_blocks, range_total, last
//   apb        in         expert_count, expert_blocks, rec_size, max_ranges
//
// A flag item is taken whenever the four-entry command queue has room for two.
// A summary item is popped in the idle state and then held in the send state until range_ch is ready.
// A range item passes in the back end through a pop, an index step, four passes through
// one shared 25 by 19 bit multiplier (two offset steps, two length steps) and a send,
// and no new command is popped until that send, so runs of emitted ranges limit the flag rate.
// Reset is synchronous and restores the register defaults; either side may stall freely.
`timescale 1ns / 1ps

module selected_block_range_coalescer_core import sbrc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  sbrc_in_if.sink               flag_ch,
  sbrc_out_if.source            range_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t       cfg;
  reg_index_t reg_sel;
  logic       wr_en;

  logic [1:0] push_n;
  cmd_t       cmd0, cmd1;
  logic       space;
  logic       q_valid;
  cmd_t       q_cmd;
  logic       q_pop;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[APB_ADDR_W-1:3]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expert_count  <= NUM_W'(1);
      cfg.expert_blocks <= NUM_W'(1);
      cfg.rec_size      <= REC_W'(128);
      cfg.max_ranges    <= CAP_W'(2048);
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_EXPERT_COUNT:  cfg.expert_count  <= pwdata[NUM_W-1:0];
        REG_EXPERT_BLOCKS: cfg.expert_blocks <= pwdata[NUM_W-1:0];
        REG_REC_SIZE:      cfg.rec_size      <= pwdata[REC_W-1:0];
        REG_MAX_RANGES:    cfg.max_ranges    <= pwdata[CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_EXPERT_COUNT:  prdata = APB_DATA_W'(cfg.expert_count);
      REG_EXPERT_BLOCKS: prdata = APB_DATA_W'(cfg.expert_blocks);
      REG_REC_SIZE:      prdata = APB_DATA_W'(cfg.rec_size);
      REG_MAX_RANGES:    prdata = APB_DATA_W'(cfg.max_ranges);
      default:           prdata = '0;
    endcase
  end

  sbrc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .flag_ch (flag_ch),
    .space   (space),
    .push_n  (push_n),
    .cmd0    (cmd0),
    .cmd1    (cmd1)
  );

  sbrc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_n  (push_n),
    .cmd0    (cmd0),
    .cmd1    (cmd1),
    .space   (space),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  sbrc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .range_ch (range_ch)
  );

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for selected_block_range_coalescer_core: flag items are driven
// from a queue, ranges and summaries are predicted per accepted item and checked in order.
// Depends on sbrc_pkg, the two channel interfaces and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
  import sbrc_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE       = 30;
  localparam int LONG_HOLD    = 400;
  localparam int RANDOM_ITEMS = 1650;
  localparam int ALTERNATE    = -1;
  localparam int MAX_SHOWN    = 40;
  localparam logic [63:0] REC_MAX = 64'd1 << 36;

  typedef struct {
    logic [EXPERT_W-1:0] expert;
    logic                sel;
    logic                last;
    int                  gap;
  } flag_item_t;

  typedef struct {
    kind_t              kind;
    status_t            status;
    logic [OFF_W-1:0]   offset;
    logic [LEN_W-1:0]   length;
    logic [BLOCK_W-1:0] first;
    logic [COUNT_W-1:0] count;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } range_item_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  sbrc_in_if  flag_if ();
  sbrc_out_if out_if ();

  selected_block_range_coalescer_core dut (
    .clk      (clk),
    .rst      (rst),
    .flag_ch  (flag_if),
    .range_ch (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  logic [NUM_W-1:0]    cf_experts  = 13'd1;
  logic [NUM_W-1:0]    cf_blocks   = 13'd1;
  logic [REC_W-1:0]    cf_record   = 37'd128;
  logic [CAP_W-1:0]    cf_capacity = 12'd2048;

  int unsigned         st_pos    = 0;
  logic                st_in_run = 1'b0;
  logic [BLOCK_W-1:0]  st_begin  = '0;
  logic [TOTAL_W-1:0]  st_done   = '0;
  status_t             st_fault  = STATUS_OK;
  logic [EXPERT_W-1:0] st_expert = '0;

  flag_item_t  flags_to_send[$];
  range_item_t ranges_due[$];

  flag_item_t drv_item;
  bit         staged  = 1'b0;
  bit         showing = 1'b0;
  int         gap_left = 0;
  bit         send_calm = 1'b0;
  bit         recv_calm = 1'b0;
  int         hold_ask  = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         stall_left = 0;
  int         errors = 0;
  int         cycles = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    if (errors < MAX_SHOWN) begin
      $display("Mismatch on %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    end
    errors++;
  endtask

  task automatic close_run(input logic [BLOCK_W-1:0] first, input int unsigned stop);
    logic [63:0] count;
    logic [63:0] index;
    range_item_t r;
    if (st_fault != STATUS_OK) return;
    if (st_done >= cf_capacity) begin
      st_fault = STATUS_CAPACITY;
      return;
    end
    count = 64'(stop) - 64'(first);
    index = 64'(st_expert) * 64'(cf_blocks) + 64'(first);
    r.kind   = KIND_RANGE;
    r.status = STATUS_OK;
    r.offset = OFF_W'(64'(HEADER_BYTES) + index * 64'(cf_record));
    r.length = LEN_W'(count * 64'(cf_record));
    r.first  = first;
    r.count  = count[COUNT_W-1:0];
    r.total  = '0;
    r.last   = 1'b0;
    ranges_due.push_back(r);
    st_done = st_done + 1'b1;
  endtask

  task automatic merge_flag(input flag_item_t f);
    int unsigned pos;
    range_item_t s;
    if (st_pos == 0) begin
      st_expert = f.expert;
      st_done   = '0;
      st_in_run = 1'b0;
      st_begin  = '0;
      if (f.expert >= cf_experts || f.expert >= MAX_EXPERTS || cf_blocks == 0 ||
          cf_blocks > MAX_BLOCKS) begin
        st_fault = STATUS_INVALID;
      end else begin
        st_fault = STATUS_OK;
      end
    end
    pos = st_pos;
    if (pos >= cf_blocks) st_fault = STATUS_INVALID;
    if (f.last && pos + 1 != cf_blocks) st_fault = STATUS_INVALID;
    if (f.sel) begin
      if (!st_in_run) begin
        st_in_run = 1'b1;
        st_begin  = pos[BLOCK_W-1:0];
      end
    end else if (st_in_run) begin
      close_run(st_begin, pos);
      st_in_run = 1'b0;
    end
    if (f.last) begin
      if (st_in_run) begin
        close_run(st_begin, pos + 1);
        st_in_run = 1'b0;
      end
      s.kind   = KIND_SUMMARY;
      s.status = st_fault;
      s.offset = '0;
      s.length = '0;
      s.first  = '0;
      s.count  = '0;
      s.total  = st_done;
      s.last   = 1'b1;
      ranges_due.push_back(s);
      st_pos = 0;
    end else if (pos < MAX_BLOCKS + 1) begin
      st_pos = pos + 1;
    end
  endtask

  function automatic bit sender_idle();
    return flags_to_send.size() == 0 && !staged && !showing;
  endfunction

  task automatic add_flag(input int expert, input bit sel, input bit last);
    flag_item_t f;
    f.expert = expert[EXPERT_W-1:0];
    f.sel    = sel;
    f.last   = last;
    f.gap    = send_calm ? 0 : $urandom_range(0, 18);
    flags_to_send.push_back(f);
  endtask

  task automatic queue_pass(input int expert, input int flags, input int density);
    bit sel;
    for (int i = 0; i < flags; i++) begin
      if (density == ALTERNATE) sel = i[0];
      else sel = ($urandom_range(0, 99) < density);
      add_flag((i == 0) ? expert : $urandom_range(0, 4095), sel, i == flags - 1);
    end
  endtask

  task automatic settle();
    do @(negedge clk); while (!sender_idle() || ranges_due.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [63:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(8 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_EXPERT_COUNT:  cf_experts  = value[NUM_W-1:0];
      REG_EXPERT_BLOCKS: cf_blocks   = value[NUM_W-1:0];
      REG_REC_SIZE:      cf_record   = value[REC_W-1:0];
      REG_MAX_RANGES:    cf_capacity = value[CAP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      flag_if.valid <= 1'b0;
    end else begin
      if (flag_if.valid && flag_if.ready) begin
        merge_flag(drv_item);
        showing = 1'b0;
      end
      if (!showing) begin
        if (!staged && flags_to_send.size() > 0) begin
          drv_item = flags_to_send.pop_front();
          staged   = 1'b1;
          gap_left = drv_item.gap;
        end
        if (staged && gap_left == 0) begin
          flag_if.valid         <= 1'b1;
          flag_if.expert_number <= drv_item.expert;
          flag_if.selected      <= drv_item.sel;
          flag_if.last_flag     <= drv_item.last;
          staged  = 1'b0;
          showing = 1'b1;
        end else begin
          flag_if.valid <= 1'b0;
          if (staged) gap_left--;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) stall_left = recv_calm ? 0 : $urandom_range(0, 18);
      if (hold_seen != hold_ask) begin
        hold_seen = hold_ask;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    range_item_t w;
    if (!rst && out_if.valid && out_if.ready) begin
      if (ranges_due.size() == 0) begin
        report("item with nothing expected", {63'd0, out_if.kind}, 64'd0);
      end else begin
        w = ranges_due.pop_front();
        if (out_if.kind !== w.kind) begin
          report("kind", 64'(out_if.kind), 64'(w.kind));
        end
        if (out_if.status !== w.status) begin
          report("status", 64'(out_if.status), 64'(w.status));
        end
        if (out_if.range_offset !== w.offset) begin
          report("range_offset", 64'(out_if.range_offset), 64'(w.offset));
        end
        if (out_if.range_length !== w.length) begin
          report("range_length", 64'(out_if.range_length), 64'(w.length));
        end
        if (out_if.start_block !== w.first) begin
          report("start_block", 64'(out_if.start_block), 64'(w.first));
        end
        if (out_if.run_blocks !== w.count) begin
          report("run_blocks", 64'(out_if.run_blocks), 64'(w.count));
        end
        if (out_if.range_total !== w.total) begin
          report("range_total", 64'(out_if.range_total), 64'(w.total));
        end
        if (out_if.last !== w.last) begin
          report("last", 64'(out_if.last), 64'(w.last));
        end
      end
    end
  end

  initial begin
    int          sent;
    int          phase;
    int          n_passes;
    int          pick;
    int          ec;
    int          bpe;
    int          ex;
    int          nflags;
    int          den;
    logic [63:0] rec;
    logic [63:0] cap;

    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    flag_if.valid         = 1'b0;
    flag_if.expert_number = '0;
    flag_if.selected      = 1'b0;
    flag_if.last_flag     = 1'b0;
    out_if.ready          = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Register defaults: one expert, one block per pass.
    queue_pass(0, 1, 100);
    queue_pass(0, 1, 0);
    queue_pass(1, 1, 100);
    queue_pass(0, 2, 100);

    settle();
    write_reg(REG_EXPERT_COUNT, 64'd4096);
    write_reg(REG_EXPERT_BLOCKS, 64'd4);
    write_reg(REG_REC_SIZE, REC_MAX);
    add_flag(4095, 1'b1, 1'b0);
    add_flag(0, 1'b1, 1'b0);
    add_flag(0, 1'b0, 1'b0);
    add_flag(4095, 1'b1, 1'b1);
    add_flag(7, 1'b1, 1'b0);
    add_flag(0, 1'b1, 1'b0);
    add_flag(0, 1'b1, 1'b1);

    settle();
    write_reg(REG_MAX_RANGES, 64'd0);
    write_reg(REG_REC_SIZE, 64'd0);
    add_flag(3, 1'b1, 1'b0);
    add_flag(0, 1'b0, 1'b0);
    add_flag(0, 1'b1, 1'b1);

    settle();
    write_reg(REG_MAX_RANGES, 64'd2048);
    queue_pass(2, 4, 100);

    settle();
    write_reg(REG_EXPERT_BLOCKS, 64'd0);
    queue_pass(0, 1, 100);
    settle();
    write_reg(REG_EXPERT_BLOCKS, 64'd4097);
    queue_pass(0, 1, 100);

    // Widest layout: short passes from the top expert close ranges at the largest offsets,
    // then end early and so report invalid arguments.
    settle();
    write_reg(REG_EXPERT_BLOCKS, 64'd4096);
    write_reg(REG_REC_SIZE, REC_MAX);
    send_calm = $urandom_range(0, 1);
    recv_calm = $urandom_range(0, 1);
    queue_pass(4095, 16, ALTERNATE);
    queue_pass(4095, 16, 100);

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      pick = $urandom_range(0, 2);
      if (pick == 0) ec = 4096;
      else if (pick == 1) ec = $urandom_range(1, 4096);
      else ec = $urandom_range(1, 8);
      pick = $urandom_range(0, 19);
      if (pick == 0) bpe = 0;
      else if (pick == 1) bpe = $urandom_range(4097, 8191);
      else if (pick < 4) bpe = $urandom_range(13, 64);
      else bpe = $urandom_range(1, 12);
      pick = $urandom_range(0, 9);
      if (pick == 0) rec = 64'd1;
      else if (pick == 1) rec = REC_MAX;
      else begin
        rec = {$urandom, $urandom} >> $urandom_range(28, 60);
        if (rec == 0) rec = 64'd1;
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) cap = 64'd2048;
      else if (pick < 8) cap = $urandom_range(0, 4);
      else cap = $urandom_range(0, 2048);
      if (phase == 0) begin
        bpe = 8;
        cap = 64'd2048;
      end
      write_reg(REG_EXPERT_COUNT, 64'(ec));
      write_reg(REG_EXPERT_BLOCKS, 64'(bpe));
      write_reg(REG_REC_SIZE, rec);
      write_reg(REG_MAX_RANGES, cap);
      // The first phase starves the output so that the block backs up onto its input.
      if (phase == 0) hold_ask++;
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      n_passes = $urandom_range(4, 12);
      repeat (n_passes) begin
        pick = $urandom_range(0, 5);
        if (phase == 0) den = $urandom_range(40, 70);
        else if (pick == 0) den = 0;
        else if (pick == 1) den = 100;
        else if (pick == 2) den = ALTERNATE;
        else den = $urandom_range(10, 90);
        ex = $urandom_range(0, ec - 1);
        pick = $urandom_range(0, 99);
        if (bpe == 0 || bpe > MAX_BLOCKS) begin
          nflags = $urandom_range(1, 6);
        end else if (pick < 80 || phase == 0) begin
          nflags = bpe;
        end else if (pick < 87 && ec < 4096) begin
          ex = $urandom_range(ec, 4095);
          nflags = bpe;
        end else if (pick < 94 && bpe > 1) begin
          nflags = $urandom_range(1, bpe - 1);
        end else begin
          nflags = bpe + $urandom_range(1, 3);
        end
        queue_pass(ex, nflags, den);
        sent += nflags;
      end
      phase++;
    end

    settle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/sbrc_pkg.sv
rtl/sbrc_in_if.sv
rtl/sbrc_out_if.sv
rtl/sbrc_front.sv
rtl/sbrc_queue.sv
rtl/sbrc_back.sv
rtl/selected_block_range_coalescer_core.sv
bench/testbench.sv
